[rtl/binary_min_heap_queue_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the heap queue unit
// Implication helpers, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define BMHQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// next-cycle implication
`define BMHQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

[rtl/bmhq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Command, status and sequencer codes for the heap queue unit.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_DEL_MIN = 3'd1,
    FN_PEEK    = 3'd2,
    FN_RAISE   = 3'd3,
    FN_LOWER   = 3'd4,
    FN_DEL_KEY = 3'd5,
    FN_CLEAR   = 3'd6,
    FN_NOP     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SU_CHK,
    ST_SU_CMP,
    ST_SD_CHK,
    ST_SD_L,
    ST_SD_R,
    ST_SD_CMP,
    ST_ROOT,
    ST_LAST_WAIT
  } state_t;

endpackage

[rtl/binary_min_heap_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Min-heap priority queue over one synchronous key RAM, driven by a sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  command   | start, busy (beat on      | func, key_value, delta
//            |   start && !busy)         |
//  result    | done (one-cycle strobe)   | result_value, status, entry_count
//  config    | cfg_valid, cfg_ready      | cfg_data (capacity_limit)
//
//  Order: every command runs to completion before the next is taken.
//  Clear, no-op, refused insert and empty peek/delete-min finish straight from
//  idle; sift up reads the parent per level, sift down the children per level,
//  all bound by the one read port of the key RAM. Raise, lower and delete-key
//  first scan the RAM, one entry per cycle, and then sift the found entry.
//  Reset clears the count; RAM contents are not cleared (only live positions
//  are read). The receiver cannot stall: done is a bare strobe.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit #(
  parameter int HEAP_DEPTH = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func,
  input  logic signed [31:0] key_value,
  input  logic signed [31:0] delta,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic [10:0]        entry_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data
);
  import bmhq_pkg::*;

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int EW = ((KEY_WIDTH > 32) ? KEY_WIDTH : 32) + 2;
  localparam logic signed [KEY_WIDTH-1:0] KMAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  localparam logic signed [KEY_WIDTH-1:0] KMIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  // key RAM, position p lives at address p-1
  logic signed [KEY_WIDTH-1:0] mem [HEAP_DEPTH];
  logic signed [KEY_WIDTH-1:0] mem_q;
  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic signed [KEY_WIDTH-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [10:0]   cap;
  func_t         op, op_next;
  logic signed [KEY_WIDTH-1:0] tmp, tmp_next, key, key_next, cval, cval_next;
  logic [CW-1:0] pos, pos_next, cpos, cpos_next, pend_pos, pend_pos_next;
  logic [CW:0]   scan, scan_next;
  logic          pend, pend_next, force_up, force_up_next;
  logic [31:0]   mag, mag_next;
  logic signed [31:0] res, res_next;
  status_t       sts, sts_next;
  logic          done_next;

  // decoded command-time values
  logic signed [KEY_WIDTH-1:0] key_in;
  logic [31:0] mag_in;
  logic        full;
  assign key_in = KEY_WIDTH'(key_value);
  assign mag_in = delta[31] ? ((delta == 32'sh8000_0000) ? 32'h7FFF_FFFF : 32'(-delta))
                            : 32'(delta);
  assign full = (32'(cnt) >= 32'(cap)) || (32'(cnt) >= 32'(HEAP_DEPTH));

  // saturating raise / clamped lower on the found key
  logic signed [EW-1:0] sum_w, dif_w;
  logic signed [KEY_WIDTH-1:0] raised, lowered;
  assign sum_w   = EW'(mem_q) + $signed({{(EW-32){1'b0}}, mag});
  assign dif_w   = EW'(mem_q) - $signed({{(EW-32){1'b0}}, mag});
  assign raised  = (sum_w > EW'(KMAX)) ? KMAX : KEY_WIDTH'(sum_w);
  assign lowered = (dif_w < EW'(KMIN)) ? KMIN + 1'b1 : KEY_WIDTH'(dif_w);

  // child / parent positions
  logic [CW:0]   lchild;
  logic [CW-1:0] parent, cnt_dec;
  logic          at_match;
  assign lchild   = {pos, 1'b0};
  assign parent   = pos >> 1;
  assign cnt_dec  = cnt - 1'b1;
  assign at_match = pend && (mem_q == key);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (func_t'(func))
            FN_INSERT:  state_next = full ? ST_IDLE : ST_SU_CHK;
            FN_DEL_MIN, FN_PEEK: state_next = (cnt == '0) ? ST_IDLE : ST_ROOT;
            FN_RAISE, FN_LOWER, FN_DEL_KEY: state_next = ST_SEARCH;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (at_match) begin
          state_next = (op == FN_RAISE) ? ST_SD_CHK : ST_SU_CHK;
        end else if (scan > (CW+1)'(cnt) && !pend) begin
          state_next = ST_IDLE;
        end
      end
      ST_SU_CHK: begin
        if (pos > 1) state_next = ST_SU_CMP;
        else         state_next = force_up ? ST_LAST_WAIT : ST_IDLE;
      end
      ST_SU_CMP: state_next = (force_up || mem_q > tmp) ? ST_SU_CHK : ST_IDLE;
      ST_SD_CHK: state_next = (lchild <= (CW+1)'(cnt)) ? ST_SD_L : ST_IDLE;
      ST_SD_L:   state_next = ((CW+1)'(cpos) != (CW+1)'(cnt)) ? ST_SD_R : ST_SD_CMP;
      ST_SD_R:   state_next = ST_SD_CMP;
      ST_SD_CMP: state_next = (tmp > cval) ? ST_SD_CHK : ST_IDLE;
      ST_ROOT:   state_next = (op == FN_PEEK) ? ST_IDLE : ST_LAST_WAIT;
      ST_LAST_WAIT: state_next = (cnt_dec == '0) ? ST_IDLE : ST_SD_CHK;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = tmp;
    cnt_next = cnt; op_next = op; tmp_next = tmp; key_next = key; cval_next = cval;
    pos_next = pos; cpos_next = cpos; pend_pos_next = pend_pos; scan_next = scan;
    pend_next = pend; force_up_next = force_up; mag_next = mag;
    res_next = res; sts_next = sts; done_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next = func_t'(func); key_next = key_in; mag_next = mag_in;
          res_next = '0; sts_next = STS_OK; force_up_next = 1'b0;
          case (func_t'(func))
            FN_INSERT: begin
              if (full) begin
                sts_next = STS_FULL; done_next = 1'b1;
              end else begin
                cnt_next = cnt + 1'b1; pos_next = cnt + 1'b1; tmp_next = key_in;
              end
            end
            FN_DEL_MIN, FN_PEEK: begin
              if (cnt == '0) begin
                sts_next = STS_EMPTY; res_next = 32'(KMIN); done_next = 1'b1;
              end else begin
                re = 1'b1; raddr = '0;
              end
            end
            FN_RAISE, FN_LOWER, FN_DEL_KEY: begin
              scan_next = (CW+1)'(1); pend_next = 1'b0;
            end
            FN_CLEAR: begin
              cnt_next = '0; done_next = 1'b1;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      ST_SEARCH: begin
        if (at_match) begin
          pos_next = pend_pos; pend_next = 1'b0;
          case (op)
            FN_RAISE: begin tmp_next = raised;  res_next = 32'(raised);  end
            FN_LOWER: begin tmp_next = lowered; res_next = 32'(lowered); end
            default: begin res_next = 32'(key); force_up_next = 1'b1; end
          endcase
        end else if (scan <= (CW+1)'(cnt)) begin
          re = 1'b1; raddr = AW'(scan - 1'b1);
          pend_next = 1'b1; pend_pos_next = CW'(scan); scan_next = scan + 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            sts_next = STS_NOT_FOUND; res_next = 32'(KMIN); done_next = 1'b1;
          end
        end
      end
      ST_SU_CHK: begin
        if (pos > 1) begin
          re = 1'b1; raddr = AW'(parent - 1'b1);
        end else if (force_up) begin
          re = 1'b1; raddr = AW'(cnt - 1'b1);
        end else begin
          we = 1'b1; waddr = AW'(pos - 1'b1); done_next = 1'b1;
        end
      end
      ST_SU_CMP: begin
        we = 1'b1; waddr = AW'(pos - 1'b1);
        if (force_up || mem_q > tmp) begin
          wdata = mem_q; pos_next = parent;
        end else begin
          done_next = 1'b1;
        end
      end
      ST_SD_CHK: begin
        if (lchild <= (CW+1)'(cnt)) begin
          re = 1'b1; raddr = AW'(lchild - 1'b1); cpos_next = CW'(lchild);
        end else begin
          we = 1'b1; waddr = AW'(pos - 1'b1); done_next = 1'b1;
        end
      end
      ST_SD_L: begin
        cval_next = mem_q;
        if ((CW+1)'(cpos) != (CW+1)'(cnt)) begin
          re = 1'b1; raddr = AW'(cpos);
        end
      end
      ST_SD_R: begin
        if (mem_q < cval) begin
          cval_next = mem_q; cpos_next = cpos + 1'b1;
        end
      end
      ST_SD_CMP: begin
        we = 1'b1; waddr = AW'(pos - 1'b1);
        if (tmp > cval) begin
          wdata = cval; pos_next = cpos;
        end else begin
          done_next = 1'b1;
        end
      end
      ST_ROOT: begin
        res_next = 32'(mem_q);
        if (op == FN_PEEK) begin
          done_next = 1'b1;
        end else begin
          re = 1'b1; raddr = AW'(cnt - 1'b1);
        end
      end
      ST_LAST_WAIT: begin
        tmp_next = mem_q; cnt_next = cnt_dec; pos_next = CW'(1); force_up_next = 1'b0;
        if (cnt_dec == '0) done_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      cap   <= 11'd1024;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      pend  <= pend_next;
      if (cfg_valid) cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next; tmp <= tmp_next; key <= key_next; cval <= cval_next;
    pos <= pos_next; cpos <= cpos_next; pend_pos <= pend_pos_next; scan <= scan_next;
    force_up <= force_up_next; mag <= mag_next; res <= res_next; sts <= sts_next;
  end

  assign busy         = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign result_value = res;
  assign status       = sts;
  assign entry_count  = 11'(cnt);

endmodule

[rtl/bmhq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks on the heap queue unit, attached by bind.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_unit_macros.svh"

module bmhq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [10:0] entry_count
);
  import bmhq_pkg::*;

  // a result beat only ever lands as the sequencer goes idle
  `BMHQ_ASSERT_IMP(a_done_idle, done, !busy)
  // an accepted command either finishes at once or keeps the unit busy
  `BMHQ_ASSERT_NXT(a_accept_moves, start && !busy, busy || done)
  // busy never rises without a command beat
  `BMHQ_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start))
  // empty status means an empty heap
  `BMHQ_ASSERT_IMP(a_empty_count, done && status == STS_EMPTY, entry_count == 11'd0)

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .entry_count(entry_count)
);

[tb/binary_min_heap_queue_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit_checker
// Watches the command, result and config channels, keeps its own heap
// and compares every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         func,
  input  logic signed [31:0] key_value,
  input  logic signed [31:0] delta,
  input  logic               done,
  input  logic signed [31:0] result_value,
  input  logic [1:0]         status,
  input  logic [10:0]        entry_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [10:0]        cfg_data,
  output int                 pending,
  output int                 errors
);
  import bmhq_pkg::*;

  localparam int DEPTH = 1024;
  localparam longint KMAX = 64'sd2147483647;
  localparam longint KMIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    status_t            sts;
    logic [10:0]        count;
  } heap_reply_t;

  longint      keys [1:DEPTH];
  int          count;
  logic [10:0] cap;
  heap_reply_t replies_due [$];

  function automatic void sift_up(int pos);
    longint t;
    int i;
    t = keys[pos];
    i = pos;
    while (i > 1 && keys[i / 2] > t) begin
      keys[i] = keys[i / 2];
      i = i / 2;
    end
    keys[i] = t;
  endfunction

  function automatic void sift_down(int pos);
    longint t;
    int i;
    int c;
    t = keys[pos];
    i = pos;
    while (2 * i <= count) begin
      c = 2 * i;
      if (c != count && keys[c + 1] < keys[c]) c++;
      if (t > keys[c]) keys[i] = keys[c];
      else break;
      i = c;
    end
    keys[i] = t;
  endfunction

  function automatic longint pop_root();
    longint top;
    top = keys[1];
    keys[1] = keys[count];
    count--;
    if (count > 0) sift_down(1);
    return top;
  endfunction

  function automatic heap_reply_t run_command(func_t f, longint k, longint d);
    heap_reply_t r;
    longint mag;
    longint v;
    int lim;
    int pos;
    mag = (d < 0) ? ((d == KMIN) ? KMAX : -d) : d;
    lim = (cap > DEPTH) ? DEPTH : int'(cap);
    r.value = '0;
    r.sts = STS_OK;
    case (f)
      FN_INSERT: begin
        if (count >= lim) r.sts = STS_FULL;
        else begin
          count++;
          keys[count] = k;
          sift_up(count);
        end
      end
      FN_DEL_MIN, FN_PEEK: begin
        if (count == 0) begin
          r.sts = STS_EMPTY;
          r.value = KMIN[31:0];
        end else r.value = 32'((f == FN_DEL_MIN) ? pop_root() : keys[1]);
      end
      FN_RAISE, FN_LOWER, FN_DEL_KEY: begin
        pos = 0;
        for (int i = 1; i <= count; i++)
          if (pos == 0 && keys[i] == k) pos = i;
        if (pos == 0) begin
          r.sts = STS_NOT_FOUND;
          r.value = KMIN[31:0];
        end else if (f == FN_RAISE) begin
          v = keys[pos];
          v = (v > KMAX - mag) ? KMAX : v + mag;
          keys[pos] = v;
          r.value = v[31:0];
          sift_down(pos);
        end else if (f == FN_LOWER) begin
          v = keys[pos];
          v = (v < KMIN + mag) ? KMIN + 1 : v - mag;
          keys[pos] = v;
          r.value = v[31:0];
          sift_up(pos);
        end else begin
          // bubble the hole to the root, then remove it
          while (pos > 1) begin
            keys[pos] = keys[pos / 2];
            pos = pos / 2;
          end
          keys[1] = k;
          r.value = 32'(pop_root());
        end
      end
      FN_CLEAR: count = 0;
      default: ;
    endcase
    r.count = count[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    heap_reply_t want;
    if (rst) begin
      replies_due.delete();
      count = 0;
      cap = 11'd1024;
      errors = 0;
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          want = replies_due.pop_front();
          if (result_value !== want.value || status !== want.sts ||
              entry_count !== want.count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp value %0d sts %0d count %0d, got %0d %0d %0d",
                       want.value, want.sts, want.count,
                       result_value, status, entry_count);
          end
        end
      end
      if (start && !busy)
        replies_due.push_back(run_command(func_t'(func), longint'(key_value),
                                          longint'(delta)));
      if (cfg_valid && cfg_ready) cap = cfg_data;
    end
    pending = replies_due.size();
  end

  initial begin
    pending = 0;
    errors = 0;
  end

endmodule

[tb/binary_min_heap_queue_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit_test
// Drives directed and random heap commands through several capacity
// settings; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit_test;
  import bmhq_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  func_t              func;
  logic signed [31:0] key_value;
  logic signed [31:0] delta;
  logic               done;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [10:0]        entry_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [10:0]        cfg_data;
  int                 pending;
  int                 errors;

  int burst_left;

  binary_min_heap_queue_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .key_value(key_value), .delta(delta), .done(done),
    .result_value(result_value), .status(status), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  binary_min_heap_queue_unit_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .key_value(key_value), .delta(delta), .done(done),
    .result_value(result_value), .status(status), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  // 4 ns clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // busy and cfg_ready only move at the rising edge, so the falling edge
  // tells whether the beat will be taken at the next rising edge
  task automatic issue(func_t f, logic [31:0] k, logic [31:0] d);
    logic taken;
    start     <= 1'b1;
    func      <= f;
    key_value <= k;
    delta     <= d;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // sender idles between bursts; start stays high inside a burst
  task automatic pace();
    if (burst_left > 0) burst_left--;
    else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // capacity write while idle; a short settle covers any trailing work
  task automatic set_capacity(logic [10:0] v);
    logic taken;
    drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  // small pool so searches usually hit; now and then a full-range key
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 16)) - 8);
  endfunction

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // fill_bias weights inserts so the capacity limit is reached
  task automatic random_run(int n, int fill_bias);
    func_t f;
    int w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < fill_bias) f = FN_INSERT;
      else if (w < 97) f = func_t'($urandom_range(0, 5));
      else f = func_t'($urandom_range(6, 7));
      issue(f, pick_key(), pick_delta());
      pace();
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    func      = FN_NOP;
    key_value = '0;
    delta     = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty heap, extremes, saturation, clamping, duplicates
    issue(FN_PEEK,    32'd0, 32'd0);
    issue(FN_DEL_MIN, 32'd0, 32'd0);
    issue(FN_RAISE,   32'd0, 32'd1);
    issue(FN_LOWER,   32'd0, 32'd1);
    issue(FN_DEL_KEY, 32'd0, 32'd0);
    issue(FN_INSERT,  32'h7fff_ffff, 32'd0);
    issue(FN_INSERT,  32'h8000_0000, 32'hffff_ffff);
    issue(FN_INSERT,  32'd0, 32'd0);
    issue(FN_INSERT,  32'hffff_ffff, 32'd0);
    issue(FN_INSERT,  32'd5, 32'd0);
    issue(FN_INSERT,  32'd5, 32'd0);
    issue(FN_PEEK,    32'd0, 32'd0);
    issue(FN_RAISE,   32'd5, 32'h8000_0000);   // saturates high
    issue(FN_LOWER,   32'd0, 32'h7fff_ffff);
    issue(FN_LOWER,   32'hffff_ffff, 32'h8000_0000);
    issue(FN_LOWER,   32'h8000_0000, 32'd1);   // clamps above the most negative
    issue(FN_DEL_KEY, 32'd5, 32'd0);
    issue(FN_DEL_KEY, 32'd99, 32'd0);          // not present
    issue(FN_RAISE,   32'd98, 32'd3);
    issue(FN_NOP,     32'hffff_ffff, 32'hffff_ffff);
    issue(FN_DEL_MIN, 32'd0, 32'd0);
    issue(FN_CLEAR,   32'd0, 32'd0);
    issue(FN_DEL_MIN, 32'd0, 32'd0);

    // capacity phases, the extremes among them
    set_capacity(11'd3);
    random_run(60, 50);
    set_capacity(11'd0);
    random_run(30, 40);
    set_capacity(11'd1);
    random_run(60, 50);
    set_capacity(11'd40);
    random_run(250, 55);
    drain();                              // one full pause mid-run
    random_run(150, 35);
    set_capacity(11'd2);                  // below the current count
    random_run(60, 30);
    set_capacity(11'd2047);
    random_run(250, 50);
    set_capacity(11'd1024);
    random_run(200, 40);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
